// ===== sv/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// types and constants of the first-fit allocator unit
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_INIT  = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOFIT  = 2'd1;
   localparam logic [1:0] ST_BAD    = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [31:0] PAGE_SIZE_RESET = 32'd16777216;
   localparam logic [16:0] OUTSTANDING_MAX = 17'd131071;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_MODIFY,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_RESCAN,
      S_INIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] alloc_offset;
      logic [31:0] alloc_size;
      logic [31:0] largest_free_bytes;
      logic [10:0] free_block_count;
      logic [16:0] live_allocations;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] request_size;
      logic [31:0] free_offset;
   } req_type_t_type;

endpackage

// ===== sv/ffa_if.sv =====
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if / ffa_csr_if
// valid/ready channels of the allocator
// ----------------------------------------------------------------------------
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [31:0] request_size;
   logic [31:0] free_offset;
   modport source (output valid, output req_type, output request_size,
                   output free_offset, input ready);
   modport sink   (input valid, input req_type, input request_size,
                   input free_offset, output ready);
endinterface

interface ffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] alloc_offset;
   logic [31:0] alloc_size;
   logic [31:0] largest_free_bytes;
   logic [10:0] free_block_count;
   logic [16:0] live_allocations;
   modport source (output valid, output status, output alloc_offset,
                   output alloc_size, output largest_free_bytes,
                   output free_block_count, output live_allocations, input ready);
   modport sink   (input valid, input status, input alloc_offset,
                   input alloc_size, input largest_free_bytes,
                   input free_block_count, input live_allocations, output ready);
endinterface

interface ffa_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/first_fit_free_list_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_unit
// first-fit free-list allocator for one page, with coalescing
// ----------------------------------------------------------------------------
// The free list lives in one single-port ram of {start, length} granule pairs,
// kept sorted by start. One request is worked at a time. After acceptance a
// request passes through decode, the search (the read address runs one entry
// ahead of the registered data), modify, a read and a write per entry moved
// when an entry is inserted or removed, the largest-block rescan and the
// loading of the response; init goes from decode through its init step.
// A finished response waits in the output register; the next request may be
// accepted and worked meanwhile, and holds in its last step until the
// register is free. After reset the unit writes entry 0 in its init step
// before it takes requests; entries beyond the count are never used.
// page_size is latched at reset and on init only; it is written while idle.
module first_fit_free_list_allocator_unit #(
   parameter int MAX_BLOCKS  = 1024,
   parameter int ALIGN_BYTES = 65536
) (
   input  logic clock,
   input  logic reset,
   ffa_req_if.sink   req,
   ffa_rsp_if.source rsp,
   ffa_csr_if.sink   csr
);
   import ffa_pkg::*;

   localparam int AW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int SH = $clog2(ALIGN_BYTES);
   localparam int GW = 33 - SH;   // granule values incl. carry headroom
   localparam logic [31:0] AMASK = 32'(ALIGN_BYTES - 1);

   // entry = {start, len}
   localparam int EW = 2 * GW;

   state_type state_ff, state_in;
   state_type state_next;

   logic [31:0]   page_size_ff;
   logic [GW-1:0] page_gran_ff, page_gran_in;
   logic [CW-1:0] count_ff, count_in;
   logic [GW-1:0] largest_ff, largest_in;
   logic [16:0]   outst_ff, outst_in;
   logic          boot_ff;   // first init after reset, no response

   logic [1:0]    op_ff;
   logic [GW-1:0] g_ff, o_ff;   // request granules, free offset granules
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;  // found / insert position
   logic          found_ff, found_in;
   logic [GW-1:0] best_ff, best_in;
   logic [GW-1:0] prev_s_ff, prev_l_ff, prev_s_in, prev_l_in;
   logic          bad_ff, bad_in;
   logic          up_ff, up_in;    // shift direction: 1 insert (move up)
   logic [EW-1:0] hold_ff, hold_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_v_ff, rsp_v_in;
   logic [1:0]    stat_ff, stat_in;
   logic [31:0]   aoff_ff, aoff_in, asz_ff, asz_in;

   logic          we;
   logic [AW-1:0] addr;
   logic [EW-1:0] wdata, rdata;
   logic [GW-1:0] rs, rl;

   ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock(clock), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

   assign rs = rdata[EW-1:GW];
   assign rl = rdata[GW-1:0];

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.status = rsp_ff.status;
   assign rsp.alloc_offset = rsp_ff.alloc_offset;
   assign rsp.alloc_size = rsp_ff.alloc_size;
   assign rsp.largest_free_bytes = rsp_ff.largest_free_bytes;
   assign rsp.free_block_count = rsp_ff.free_block_count;
   assign rsp.live_allocations = rsp_ff.live_allocations;

   // request decode values
   logic [32:0]   sz_up;
   logic [GW-1:0] req_g, req_o;
   assign sz_up = {1'b0, req.request_size} + 33'(AMASK);
   assign req_g = GW'(sz_up >> SH);
   assign req_o = GW'({1'b0, req.free_offset} >> SH);

   logic [GW:0] o_end;
   assign o_end = {1'b0, o_ff} + {1'b0, g_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req.valid) state_in = S_DECODE;
         S_DECODE:   state_in = S_SCAN;
         default:    ;
      endcase
      // remaining transitions are decided in the datapath block below
   end

   // datapath and sequencing
   always_comb begin
      logic [GW:0] e;
      logic        mp, mn;
      state_type   nx;
      nx = state_in;
      idx_in = idx_ff; pos_in = pos_ff; found_in = found_ff; best_in = best_ff;
      prev_s_in = prev_s_ff; prev_l_in = prev_l_ff; bad_in = bad_ff;
      up_in = up_ff; hold_in = hold_ff;
      count_in = count_ff; largest_in = largest_ff; outst_in = outst_ff;
      page_gran_in = page_gran_ff;
      stat_in = stat_ff; aoff_in = aoff_ff; asz_in = asz_ff;
      rsp_in = rsp_ff; rsp_v_in = rsp_v_ff;
      we = 1'b0; addr = idx_ff[AW-1:0]; wdata = '0;
      e = '0; mp = 1'b0; mn = 1'b0;
      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0; found_in = 1'b0; bad_in = 1'b0;
            stat_in = ST_OK; aoff_in = '0; asz_in = '0;
            prev_s_in = '0; prev_l_in = '0;
         end
         S_DECODE: begin
            addr = '0;
            idx_in = '0; pos_in = count_ff;
            case (op_ff)
               REQ_ALLOC: if (g_ff == '0) begin stat_in = ST_BAD; nx = S_DONE; end
               REQ_FREE: begin
                  if (bad_ff || o_end > {1'b0, page_gran_ff}) begin
                     stat_in = ST_BAD; nx = S_DONE;
                  end
               end
               REQ_INIT: nx = S_INIT;
               default: begin stat_in = ST_BAD; nx = S_DONE; end
            endcase
            if (nx == S_SCAN && count_ff == '0) nx = S_MODIFY;
            if (nx == S_SCAN) idx_in = '0;
         end
         S_SCAN: begin
            // rdata holds entry idx (address issued last cycle)
            e = {1'b0, rs} + {1'b0, rl};
            if (op_ff == REQ_ALLOC) begin
               if (rl >= g_ff) begin
                  found_in = 1'b1; pos_in = idx_ff; prev_s_in = rs; prev_l_in = rl;
                  nx = S_MODIFY;
               end
            end else begin
               if ({1'b0, rs} < o_end && e > {1'b0, o_ff}) begin
                  stat_in = ST_BAD; nx = S_DONE;
               end else if (!found_in && rs > o_ff) begin
                  found_in = 1'b1; pos_in = idx_ff; hold_in = rdata;
               end else if (!found_in) begin
                  prev_s_in = rs; prev_l_in = rl;
                  bad_in = 1'b1;  // a previous entry exists
               end
            end
            if (nx == S_SCAN) begin
               if (idx_ff + 1'b1 >= count_ff) nx = S_MODIFY;
               else idx_in = idx_ff + 1'b1;
            end
            addr = idx_in[AW-1:0];
         end
         S_MODIFY: begin
            if (op_ff == REQ_ALLOC) begin
               if (!found_ff) begin stat_in = ST_NOFIT; nx = S_DONE; end
               else begin
                  aoff_in = 32'({1'b0, prev_s_ff}) << SH;
                  asz_in = 32'({1'b0, g_ff}) << SH;
                  if (outst_ff < OUTSTANDING_MAX) outst_in = outst_ff + 1'b1;
                  addr = pos_ff[AW-1:0];
                  if (prev_l_ff != g_ff) begin
                     we = 1'b1; wdata = {prev_s_ff + g_ff, prev_l_ff - g_ff};
                     nx = S_RESCAN;
                  end else begin
                     count_in = count_ff - 1'b1; up_in = 1'b0; idx_in = pos_ff;
                     nx = S_SHIFT_RD;
                  end
               end
            end else begin
               mp = bad_ff && (prev_s_ff + prev_l_ff == o_ff);
               mn = found_ff && (GW'(o_end) == hold_ff[EW-1:GW]);
               if (outst_ff != '0) outst_in = outst_ff - 1'b1;
               if (mp && mn) begin
                  addr = AW'(pos_ff - 1'b1); we = 1'b1;
                  wdata = {prev_s_ff, prev_l_ff + g_ff + hold_ff[GW-1:0]};
                  count_in = count_ff - 1'b1; up_in = 1'b0; idx_in = pos_ff;
                  nx = S_SHIFT_RD;
               end else if (mp) begin
                  addr = AW'(pos_ff - 1'b1); we = 1'b1;
                  wdata = {prev_s_ff, prev_l_ff + g_ff}; nx = S_RESCAN;
               end else if (mn) begin
                  addr = pos_ff[AW-1:0]; we = 1'b1;
                  wdata = {o_ff, hold_ff[GW-1:0] + g_ff}; nx = S_RESCAN;
               end else if (count_ff >= CW'(MAX_BLOCKS)) begin
                  outst_in = outst_ff; stat_in = ST_FULL; nx = S_DONE;
               end else begin
                  count_in = count_ff + 1'b1; up_in = 1'b1; idx_in = count_ff;
                  nx = S_SHIFT_RD;
               end
            end
            if (nx == S_RESCAN) begin idx_in = '0; best_in = '0; end
         end
         S_SHIFT_RD: begin
            // remove: entry k <= entry k+1 for k = idx..count-1 (count already new)
            // insert: entry k <= entry k-1 for k = idx down to pos+1
            if (up_ff) begin
               if (idx_ff == pos_ff) begin
                  addr = pos_ff[AW-1:0]; we = 1'b1; wdata = {o_ff, g_ff};
                  idx_in = '0; best_in = '0; nx = S_RESCAN;
               end else begin
                  addr = AW'(idx_ff - 1'b1); nx = S_SHIFT_WR;
               end
            end else begin
               if (idx_ff >= count_ff) begin
                  idx_in = '0; best_in = '0; nx = S_RESCAN;
               end else begin
                  addr = AW'(idx_ff + 1'b1); nx = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            addr = idx_ff[AW-1:0]; we = 1'b1; wdata = rdata;
            idx_in = up_ff ? idx_ff - 1'b1 : idx_ff + 1'b1;
            nx = S_SHIFT_RD;
         end
         S_RESCAN: begin
            // address idx issued, data arrives next cycle; pos_ff counts the lag
            addr = idx_ff[AW-1:0];
            if (pos_ff == '1) begin
               if (rl > best_ff) best_in = rl;
            end
            if (idx_ff == count_ff) begin
               if (pos_ff != '1 || count_ff == '0) begin
                  // flush: count zero means no data pending
                  largest_in = (pos_ff == '1 && rl > best_ff) ? rl : best_ff;
                  if (count_ff == '0) largest_in = '0;
                  nx = S_DONE;
               end
            end
            if (nx == S_RESCAN) begin
               pos_in = '1;
               if (idx_ff == count_ff) pos_in = '0;
               if (idx_ff != count_ff) idx_in = idx_ff + 1'b1;
            end
         end
         S_INIT: begin
            page_gran_in = GW'({1'b0, page_size_ff} >> SH);
            addr = '0; we = 1'b1; wdata = {{GW{1'b0}}, page_gran_in};
            count_in = (page_gran_in != '0) ? CW'(1) : '0;
            largest_in = page_gran_in; outst_in = '0;
            // the init after reset gives no response
            nx = boot_ff ? S_IDLE : S_DONE;
         end
         S_DONE: begin
            // hold here while the previous response still waits
            if (!rsp_v_ff || rsp.ready) begin
               rsp_in.status = stat_ff;
               rsp_in.alloc_offset = (stat_ff == ST_OK) ? aoff_ff : '0;
               rsp_in.alloc_size = (stat_ff == ST_OK) ? asz_ff : '0;
               rsp_in.largest_free_bytes = 32'({1'b0, largest_ff}) << SH;
               rsp_in.free_block_count = 11'(count_ff);
               rsp_in.live_allocations = outst_ff;
               rsp_v_in = 1'b1;
               nx = S_IDLE;
            end
         end
         default: nx = S_IDLE;
      endcase
      state_next = nx;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req.valid && req.ready) begin
         op_ff <= req.req_type;
         g_ff <= (req.req_type == REQ_FREE) ? GW'({1'b0, req.request_size} >> SH)
                                           : req_g;
         o_ff <= req_o;
      end
      if (reset) begin
         state_ff <= S_INIT;
         boot_ff <= 1'b1;
         page_size_ff <= PAGE_SIZE_RESET;
         page_gran_ff <= GW'({1'b0, PAGE_SIZE_RESET} >> SH);
         count_ff <= CW'(1);
         largest_ff <= GW'({1'b0, PAGE_SIZE_RESET} >> SH);
         outst_ff <= '0;
         rsp_v_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         if (csr.valid && csr.ready) page_size_ff <= csr.data;
         if (state_ff == S_INIT) boot_ff <= 1'b0;
         state_ff <= state_next;
         page_gran_ff <= page_gran_in;
         count_ff <= count_in;
         largest_ff <= largest_in;
         outst_ff <= outst_in;
         rsp_v_ff <= rsp_v_in;
         if (state_ff == S_IDLE && req.valid && req.ready)
            bad_ff <= (req.req_type == REQ_FREE) &&
                      (req.request_size == '0 || (req.request_size & AMASK) != '0 ||
                       (req.free_offset & AMASK) != '0);
         else bad_ff <= (state_ff == S_DECODE) ? 1'b0 : bad_in;
      end
      idx_ff <= idx_in; pos_ff <= pos_in; found_ff <= found_in; best_ff <= best_in;
      prev_s_ff <= prev_s_in; prev_l_ff <= prev_l_in; up_ff <= up_in;
      hold_ff <= hold_in; rsp_ff <= rsp_in; stat_ff <= stat_in;
      aoff_ff <= aoff_in; asz_ff <= asz_in;
   end

   // reset enters the init step once, which writes entry 0 as {0, page}
endmodule

// ===== sv/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// generic single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
